### hw/rtl/frx_pkg.sv
// ----------------------------------------------------------------------------
// Frame receiver package
// Types, header layout constants, event codes and the CRC-16 byte update
// shared by the frame receiver modules.
// ----------------------------------------------------------------------------
package frx_pkg;

   // Header byte offsets within a frame.
   localparam logic [2:0] HDR_MAGIC   = 3'd0;
   localparam logic [2:0] HDR_FLAGS   = 3'd1;
   localparam logic [2:0] HDR_LEN_HI  = 3'd2;
   localparam logic [2:0] HDR_LEN_LO  = 3'd3;
   localparam logic [2:0] HDR_CRC_HI  = 3'd4;
   localparam logic [2:0] HDR_CRC_LO  = 3'd5;
   localparam logic [2:0] HDR_SEQ_HI  = 3'd6;
   localparam logic [2:0] HDR_SEQ_LO  = 3'd7;

   // Flag bits in the header flags byte.
   localparam int unsigned ACK_FLAG_BIT = 4;
   localparam int unsigned ERR_FLAG_BIT = 5;

   // Reflected CRC-16/ARC polynomial.
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // Error counter saturates at all ones.
   localparam logic [3:0] ERR_COUNT_MAX = 4'hF;

   // Register reset values.
   localparam logic [7:0]  MAGIC_RESET     = 8'hAB;
   localparam logic [15:0] MAX_LEN_RESET   = 16'd248;
   localparam logic [3:0]  ERR_LIMIT_RESET = 4'd3;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_MAGIC_VALUE = 2'd0,
      CSR_MAX_PAYLOAD = 2'd1,
      CSR_ERROR_LIMIT = 2'd2
   } csr_index_type;

   // Result event codes.
   typedef enum logic [2:0] {
      EV_PAYLOAD    = 3'd0,
      EV_DATA_GOOD  = 3'd1,
      EV_DATA_CRC   = 3'd2,
      EV_ACK_OK     = 3'd3,
      EV_ACK_ERROR  = 3'd4,
      EV_BAD_MAGIC  = 3'd5,
      EV_BAD_LENGTH = 3'd6
   } event_type;

   // One result word.
   typedef struct packed {
      event_type   event_res;
      logic [7:0]  byte_value;
      logic        byte_valid;
      logic        frame_end;
      logic [15:0] seq_num;
      logic [15:0] body_len;
      logic        reset_request;
   } result_type;

   // Handshake between the input stage and the rest of the pipeline.
   typedef struct packed {
      logic fire;     // the held byte is processed this cycle
   } flow_type;

   // CRC-16/ARC update by one byte, bit by bit, LSB first.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                            input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

### hw/rtl/frx_input_stage.sv
// ----------------------------------------------------------------------------
// Frame receiver input stage
// Holds one received byte and releases it when the result side can advance.
// ----------------------------------------------------------------------------
module frx_input_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_rx_byte,
   input  logic             advance,
   output frx_pkg::flow_type flow,
   output logic [7:0]       byte_out
);
   import frx_pkg::*;

   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic       accept;
   logic       fire;

   // The held word is consumed whenever the result register can move.
   assign fire      = in_valid_ff & advance;
   assign req_stall = in_valid_ff & ~advance;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Byte register, loaded on accept only.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   assign flow.fire    = fire;
   assign byte_out     = in_byte_ff;

endmodule

### hw/rtl/frx_parser.sv
// ----------------------------------------------------------------------------
// Frame receiver parser
// Configuration registers, frame state and the per-byte header, payload and
// CRC logic. Produces at most one result for each processed byte.
// ----------------------------------------------------------------------------
module frx_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data,
   input  frx_pkg::flow_type  flow,
   input  logic [7:0]         rx_byte,
   output logic               has_result,
   output frx_pkg::result_type result
);
   import frx_pkg::*;

   // Configuration registers.
   logic [7:0]  magic_ff;
   logic [15:0] max_len_ff;
   logic [3:0]  err_limit_ff;

   // Frame state.
   logic [15:0] pos_ff,        pos_in;
   logic        in_payload_ff, in_payload_in;
   logic [7:0]  flags_ff,      flags_in;
   logic [15:0] len_ff,        len_in;
   logic [15:0] ecrc_ff,       ecrc_in;
   logic [15:0] seq_ff,        seq_in;
   logic [15:0] crc_ff,        crc_in;
   logic [3:0]  err_cnt_ff,    err_cnt_in;

   logic [3:0]  err_cnt_inc;
   logic        err_over;
   logic [15:0] pos_next;
   logic [15:0] crc_next;
   logic [15:0] seq_full;
   logic        is_ack;
   logic        ack_event_err;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff     <= MAGIC_RESET;
         max_len_ff   <= MAX_LEN_RESET;
         err_limit_ff <= ERR_LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_MAGIC_VALUE: magic_ff     <= csr_data[7:0];
            CSR_MAX_PAYLOAD: max_len_ff   <= csr_data;
            CSR_ERROR_LIMIT: err_limit_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // Saturating increment of the error count, and its limit check.
   assign err_cnt_inc   = (err_cnt_ff == ERR_COUNT_MAX) ? err_cnt_ff : err_cnt_ff + 4'd1;
   assign err_over      = err_cnt_inc > err_limit_ff;
   assign pos_next      = pos_ff + 16'd1;
   assign crc_next      = crc_byte(crc_ff, rx_byte);
   assign seq_full      = {seq_ff[15:8], rx_byte};
   assign is_ack        = flags_ff[ACK_FLAG_BIT];
   assign ack_event_err = flags_ff[ERR_FLAG_BIT];

   // Per-byte step.
   always_comb begin
      pos_in        = pos_ff;
      in_payload_in = in_payload_ff;
      flags_in      = flags_ff;
      len_in        = len_ff;
      ecrc_in       = ecrc_ff;
      seq_in        = seq_ff;
      crc_in        = crc_ff;
      err_cnt_in    = err_cnt_ff;
      has_result    = 1'b0;
      result        = '0;

      if (!in_payload_ff) begin
         pos_in = pos_next;
         case (pos_ff[2:0])
            HDR_MAGIC: begin
               flags_in = '0;
               len_in   = '0;
               ecrc_in  = '0;
               seq_in   = '0;
               crc_in   = '0;
               if (rx_byte != magic_ff) begin
                  err_cnt_in           = err_cnt_inc;
                  pos_in               = '0;
                  has_result           = 1'b1;
                  result.event_res     = EV_BAD_MAGIC;
                  result.frame_end     = 1'b1;
                  result.reset_request = err_over;
               end
            end
            HDR_FLAGS:  flags_in = rx_byte;
            HDR_LEN_HI: len_in   = {rx_byte, 8'h00};
            HDR_LEN_LO: begin
               len_in = {len_ff[15:8], rx_byte};
               if ({len_ff[15:8], rx_byte} > max_len_ff) begin
                  err_cnt_in            = err_cnt_inc;
                  pos_in                = '0;
                  has_result            = 1'b1;
                  result.event_res      = EV_BAD_LENGTH;
                  result.frame_end      = 1'b1;
                  result.body_len       = {len_ff[15:8], rx_byte};
                  result.reset_request  = err_over;
               end
            end
            HDR_CRC_HI: ecrc_in = {rx_byte, 8'h00};
            HDR_CRC_LO: ecrc_in = {ecrc_ff[15:8], rx_byte};
            HDR_SEQ_HI: seq_in  = {rx_byte, 8'h00};
            HDR_SEQ_LO: begin
               seq_in = seq_full;
               pos_in = '0;
               if (len_ff == 16'd0) begin
                  // Empty payload: the outcome comes with the last header byte.
                  has_result         = 1'b1;
                  result.frame_end   = 1'b1;
                  result.seq_num     = seq_full;
                  if (is_ack) begin
                     result.event_res = ack_event_err ? EV_ACK_ERROR : EV_ACK_OK;
                  end else if (crc_ff != ecrc_ff) begin
                     err_cnt_in           = err_cnt_inc;
                     result.event_res     = EV_DATA_CRC;
                     result.reset_request = err_over;
                  end else begin
                     result.event_res = EV_DATA_GOOD;
                  end
               end else begin
                  in_payload_in = 1'b1;
               end
            end
            default: ;
         endcase
      end else begin
         // Payload byte.
         pos_in                = pos_next;
         result.seq_num        = seq_ff;
         result.body_len       = len_ff;
         if (is_ack) begin
            if (pos_next >= len_ff) begin
               pos_in           = '0;
               in_payload_in    = 1'b0;
               has_result       = 1'b1;
               result.frame_end = 1'b1;
               result.event_res = ack_event_err ? EV_ACK_ERROR : EV_ACK_OK;
            end
         end else begin
            crc_in            = crc_next;
            has_result        = 1'b1;
            result.byte_value = rx_byte;
            result.byte_valid = 1'b1;
            result.event_res  = EV_PAYLOAD;
            if (pos_next >= len_ff) begin
               pos_in           = '0;
               in_payload_in    = 1'b0;
               result.frame_end = 1'b1;
               if (crc_next != ecrc_ff) begin
                  err_cnt_in           = err_cnt_inc;
                  result.event_res     = EV_DATA_CRC;
                  result.reset_request = err_over;
               end else begin
                  result.event_res = EV_DATA_GOOD;
               end
            end
         end
      end
   end

   // Frame state registers, updated when a byte is processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         in_payload_ff <= 1'b0;
         flags_ff      <= '0;
         len_ff        <= '0;
         ecrc_ff       <= '0;
         seq_ff        <= '0;
         crc_ff        <= '0;
         err_cnt_ff    <= '0;
      end else if (flow.fire) begin
         pos_ff        <= pos_in;
         in_payload_ff <= in_payload_in;
         flags_ff      <= flags_in;
         len_ff        <= len_in;
         ecrc_ff       <= ecrc_in;
         seq_ff        <= seq_in;
         crc_ff        <= crc_in;
         err_cnt_ff    <= err_cnt_in;
      end
   end

endmodule

### hw/rtl/frx_output_stage.sv
// ----------------------------------------------------------------------------
// Frame receiver output stage
// Result register with valid and stall towards the consumer.
// ----------------------------------------------------------------------------
module frx_output_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic                has_result,
   input  frx_pkg::result_type result,
   output logic                advance,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output frx_pkg::result_type rsp_word
);
   import frx_pkg::*;

   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_word_ff;

   // The register can move when it is empty or its word is being taken.
   assign advance      = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid_in = advance ? (fire & has_result) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && has_result) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

### hw/rtl/frame_receiver_crc_ack_unit.sv
// ----------------------------------------------------------------------------
// Frame receiver with CRC and ack reporting
// Parses framed byte streams, checks magic, length and CRC-16/ARC, passes
// payload bytes through and reports each frame's outcome.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake              Word
//   req_     in         req_valid / req_stall  req_rx_byte
//   rsp_     out        rsp_valid / rsp_stall  event, byte, flags, seq, length
//   csr_     in         csr_write              csr_index, csr_data
//
// One byte is taken every cycle while req_stall is low; a byte's result word
// reaches the result ports through the input register and then the result
// register.
// Synchronous active-high reset restores register defaults and frame state.
// A stalled result holds in the result register; the byte behind it waits in
// the input register, so req_stall rises only when both are full.
// ----------------------------------------------------------------------------
module frame_receiver_crc_ack_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_res,
   output logic [7:0]  rsp_byte_value,
   output logic        rsp_byte_valid,
   output logic        rsp_frame_end,
   output logic [15:0] rsp_seq_num,
   output logic [15:0] rsp_body_len,
   output logic        rsp_reset_request,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import frx_pkg::*;

   flow_type   flow;
   logic       advance;
   logic [7:0] held_byte;
   logic       has_result;
   result_type result;
   result_type rsp_word;

   frx_input_stage u_input (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .flow        (flow),
      .byte_out    (held_byte)
   );

   frx_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .flow       (flow),
      .rx_byte    (held_byte),
      .has_result (has_result),
      .result     (result)
   );

   frx_output_stage u_output (
      .clock      (clock),
      .reset      (reset),
      .fire       (flow.fire),
      .has_result (has_result),
      .result     (result),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word)
   );

   // Result word onto the ports.
   assign rsp_event_res      = rsp_word.event_res;
   assign rsp_byte_value     = rsp_word.byte_value;
   assign rsp_byte_valid     = rsp_word.byte_valid;
   assign rsp_frame_end      = rsp_word.frame_end;
   assign rsp_seq_num        = rsp_word.seq_num;
   assign rsp_body_len       = rsp_word.body_len;
   assign rsp_reset_request  = rsp_word.reset_request;

endmodule
